### sv/rbpa_pkg.sv
// Shared types, sizes and helpers for the reference-counted block pool allocator.
package rbpa_pkg;

    localparam int POOL_BLOCKS = 192;
    localparam int REF_BITS    = 8;
    localparam int MAP_WORDS   = (POOL_BLOCKS + 31) / 32;
    localparam int ADDR_W      = $clog2(POOL_BLOCKS);
    localparam int BLK_W       = 8;
    localparam int CNT_W       = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADDREF  = 2'd2,
        OP_PEEK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    // Count store write / valid-bit update request
    typedef struct packed {
        logic                we;
        logic                set_valid;
        logic                clr_valid;
        logic [ADDR_W-1:0]   addr;
        logic [REF_BITS-1:0] data;
    } t_ref_wr;

    // Result of the free-map scan
    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] blk;
    } t_scan;

    // Highest set bit of one map word
    function automatic logic [4:0] hi_bit(input logic [31:0] w);
        logic [4:0] idx;
        idx = 5'd0;
        for (int b = 0; b < 32; b++) begin
            if (w[b]) idx = 5'(b);
        end
        return idx;
    endfunction

    // Count widened to the 8-bit result field, saturated
    function automatic logic [7:0] ref_to_out(input logic [REF_BITS-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return (w > 16'd255) ? 8'hFF : w[7:0];
    endfunction

endpackage

### sv/rbpa_free_scan.sv
// Free-map priority scan: lowest word holding a free block, highest free bit in it.
module rbpa_free_scan (
    input  logic [rbpa_pkg::POOL_BLOCKS-1:0] i_free_map,
    output rbpa_pkg::t_scan                  o_scan
);
    import rbpa_pkg::*;

    logic [MAP_WORDS*32-1:0] free_pad;
    logic [MAP_WORDS-1:0]    word_any;
    logic [4:0]              word_hi [MAP_WORDS];

    assign free_pad = (MAP_WORDS*32)'(i_free_map);

    always_comb begin
        for (int w = 0; w < MAP_WORDS; w++) begin
            word_any[w] = |free_pad[w*32 +: 32];
            word_hi[w]  = hi_bit(free_pad[w*32 +: 32]);
        end
    end

    // Walk down so the lowest non-empty word wins
    always_comb begin
        o_scan.found = 1'b0;
        o_scan.blk   = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (word_any[w]) begin
                o_scan.found = 1'b1;
                o_scan.blk   = BLK_W'(w * 32 + int'(word_hi[w]));
            end
        end
    end

endmodule

### sv/rbpa_ref_store.sv
// Reference count memory with per-block valid bits and a registered, bypassed read.
module rbpa_ref_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_clear_all,
    input  logic                             i_rd_en,
    input  logic [rbpa_pkg::ADDR_W-1:0]      i_rd_addr,
    input  rbpa_pkg::t_ref_wr                i_wr,
    output logic [rbpa_pkg::REF_BITS-1:0]    o_rd_data,
    output logic [rbpa_pkg::POOL_BLOCKS-1:0] o_valid
);
    import rbpa_pkg::*;

    logic [REF_BITS-1:0]    r_mem [POOL_BLOCKS];
    logic [REF_BITS-1:0]    r_rd_data;
    logic [POOL_BLOCKS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // same-edge write to the address being read is forwarded
        if (i_rd_en) begin
            if (i_wr.we && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    // a valid bit marks a block with a nonzero count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear_all) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_wr.addr] <= 1'b1;
        end else if (i_wr.clr_valid) begin
            r_valid[i_wr.addr] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule

### sv/refcounted_block_pool_allocator_unit.sv
// Top level of the reference-counted block pool allocator.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready op, block_number
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready granted, status, in use, peak, refs
//  cfg       in   i_cfg_valid/o_cfg_ready         pool_size
//
// One request per cycle sustained while the output is not stalled; each beat loads the request
// and count read registers, and the result register loads when the request stage advances.
// Reset is synchronous, active low, and leaves every block busy with a pool size of zero.
// A stalled output holds the request stage, which in turn drops o_s_axis_tready.
module refcounted_block_pool_allocator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [1:0] operation, [9:2] block_number
    input  logic [rbpa_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] granted_block, [9:8] status, [17:10] blocks_in_use,
    // [25:18] peak_in_use, [33:26] refs_after
    output logic [rbpa_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [7:0]                         i_cfg_data       // [7:0] pool_size
);
    import rbpa_pkg::*;

    // request stage
    logic             r_a_valid;
    t_op              r_a_op;
    logic [BLK_W-1:0] r_a_blk;

    // result register
    logic             r_o_valid;
    logic [BLK_W-1:0] r_o_granted;
    t_status          r_o_status;
    logic [CNT_W-1:0] r_o_in_use;
    logic [CNT_W-1:0] r_o_peak;
    logic [7:0]       r_o_refs;

    logic [POOL_BLOCKS-1:0] r_free_map, n_free_map;
    logic [CNT_W-1:0]       r_in_use,   n_in_use;
    logic [CNT_W-1:0]       r_peak,     n_peak;

    logic                   s_beat, cfg_beat, a_adv;
    t_scan                  scan;
    t_ref_wr                wr, wr_gated;
    logic [REF_BITS-1:0]    cnt_cur;
    logic [POOL_BLOCKS-1:0] valid_vec;
    logic                   in_range, blk_valid;
    logic [ADDR_W-1:0]      a_addr;
    logic [BLK_W-1:0]       n_granted;
    t_status                n_status;
    logic [7:0]             n_refs;
    logic [15:0]            seed_n;

    assign cfg_beat        = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready     = 1'b1;
    assign a_adv           = r_a_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || a_adv;
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;

    rbpa_free_scan u_scan (
        .i_free_map (r_free_map),
        .o_scan     (scan)
    );

    assign wr_gated = a_adv ? wr : '0;

    rbpa_ref_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear_all (cfg_beat),
        .i_rd_en     (s_beat),
        .i_rd_addr   (ADDR_W'(i_s_axis_tdata[9:2])),
        .i_wr        (wr_gated),
        .o_rd_data   (cnt_cur),
        .o_valid     (valid_vec)
    );

    assign a_addr    = ADDR_W'(r_a_blk);
    assign in_range  = int'(r_a_blk) < POOL_BLOCKS;
    assign blk_valid = in_range && valid_vec[a_addr];

    always_comb begin
        n_free_map = r_free_map;
        n_in_use   = r_in_use;
        n_peak     = r_peak;
        n_granted  = r_a_blk;
        n_status   = ST_OK;
        n_refs     = 8'd0;
        wr         = '0;
        wr.addr    = a_addr;

        case (r_a_op)
            OP_ALLOC: begin
                n_granted = '0;
                if (scan.found) begin
                    n_granted                    = scan.blk;
                    n_free_map[ADDR_W'(scan.blk)] = 1'b0;
                    wr.we        = 1'b1;
                    wr.set_valid = 1'b1;
                    wr.addr      = ADDR_W'(scan.blk);
                    wr.data      = REF_ONE;
                    if (r_in_use != {CNT_W{1'b1}}) n_in_use = r_in_use + 1'b1;
                    if (n_in_use > r_peak) n_peak = n_in_use;
                    n_refs = 8'd1;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            OP_RELEASE: begin
                if (!blk_valid) begin
                    n_status = ST_BAD;
                end else if (cnt_cur > REF_ONE) begin
                    wr.we   = 1'b1;
                    wr.data = cnt_cur - 1'b1;
                    n_refs  = ref_to_out(wr.data);
                end else begin
                    // last reference: block goes back to the free map
                    wr.clr_valid       = 1'b1;
                    n_free_map[a_addr] = 1'b1;
                    if (r_in_use != '0) n_in_use = r_in_use - 1'b1;
                end
            end
            OP_ADDREF: begin
                if (!blk_valid) begin
                    n_status = ST_BAD;
                end else begin
                    wr.we   = 1'b1;
                    wr.data = (cnt_cur == REF_MAX) ? cnt_cur : cnt_cur + 1'b1;
                    n_refs  = ref_to_out(wr.data);
                end
            end
            default: begin
                if (blk_valid) n_refs = ref_to_out(cnt_cur);
            end
        endcase
    end

    assign seed_n = (int'(i_cfg_data) > POOL_BLOCKS) ? 16'(POOL_BLOCKS) : 16'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= '0;
            r_in_use   <= '0;
            r_peak     <= '0;
        end else if (cfg_beat) begin
            for (int i = 0; i < POOL_BLOCKS; i++) begin
                r_free_map[i] <= (16'(i) < seed_n);
            end
            r_in_use <= '0;
        end else if (a_adv) begin
            r_free_map <= n_free_map;
            r_in_use   <= n_in_use;
            r_peak     <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_beat) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_a_op  <= t_op'(i_s_axis_tdata[1:0]);
            r_a_blk <= i_s_axis_tdata[9:2];
        end
        if (a_adv) begin
            r_o_granted <= n_granted;
            r_o_status  <= n_status;
            r_o_in_use  <= n_in_use;
            r_o_peak    <= n_peak;
            r_o_refs    <= n_refs;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'd0, r_o_refs, r_o_peak, r_o_in_use,
                              r_o_status, r_o_granted};

endmodule
